### hw/rtl/sieve_pkg.sv
`timescale 1ns / 1ps

package sieve_pkg;

   // Fixed field widths of the two channels.
   localparam int LIMIT_W     = 32;
   localparam int COUNT_W     = 19;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   // Defaults for the top-level parameters.
   localparam int WORD_BITS_DEFAULT = 64;
   localparam int MAX_WORDS_DEFAULT = 4096;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RANGE,
      ST_CLEAR,
      ST_SIEVE_TOP,
      ST_SIEVE_CHK,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_ADV1,
      ST_ADV2,
      ST_COUNT_RD,
      ST_COUNT_ADD,
      ST_DONE
   } state_type;

endpackage

### hw/rtl/odd_only_bit_sieve_prime_count.sv
`timescale 1ns / 1ps

// Odd-only sieve of Eratosthenes with a prime count.
//
// A transfer on the req_ channel carries a limit n. The block works out
// L = floor((n-1)/(2*WORD_BITS)) bitmap words, clears them, sieves the odd
// numbers 3 .. 2*WORD_BITS*L+1 and answers with one transfer on the rsp_
// channel: the number of primes in that range, two included. When L exceeds
// MAX_WORDS no sieving is done and the answer has too_large set and a zero
// count.
//
// The bitmap memory has one write port and one registered read port. The
// clear pass writes one word per cycle and finds L on the way by stepping the
// limit down by 2*WORD_BITS per word, every mark is a read-modify-write of one
// word, each candidate goes through ST_SIEVE_TOP, ST_SIEVE_CHK, ST_ADV1 and
// ST_ADV2, and the final count reads one word at a time. An oversized limit
// goes from ST_RANGE straight to ST_DONE. Items are handled one at a time;
// req_tready is high only while idle, which is the cycle after the answer has
// been loaded into the output register.
//
// The result sits in an output register. While the receiver stalls, a new
// limit is still accepted and sieved; its answer waits until the older one
// has been taken. Reset is synchronous and clears the state and rsp_tvalid;
// the bitmap needs no reset because each run clears the words it reads.
module odd_only_bit_sieve_prime_count #(
   parameter int WORD_BITS = sieve_pkg::WORD_BITS_DEFAULT,
   parameter int MAX_WORDS = sieve_pkg::MAX_WORDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] limit
   input  logic [sieve_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [18:0] prime_count, [19] too_large, [23:20] zero
   output logic [sieve_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import sieve_pkg::*;

   localparam int AW      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   // Word positions may run a few times past L while a mark walk overshoots.
   localparam int WW      = $clog2(MAX_WORDS + 1) + 3;
   localparam int BW      = $clog2(WORD_BITS);
   localparam int DIVISOR = 2 * WORD_BITS;
   // Smallest value of n-1 that needs more than MAX_WORDS words.
   localparam int OVER_AT = (MAX_WORDS + 1) * DIVISOR;
   localparam int PCW     = $clog2(WORD_BITS + 1);

   // Adds two odd-number positions kept as (word, bit) pairs.
   function automatic logic [WW+BW-1:0] pos_add(input logic [WW-1:0] aw,
                                                input logic [BW-1:0] ab,
                                                input logic [WW-1:0] bw,
                                                input logic [BW-1:0] bb);
      logic [BW:0] sb;
      logic [WW-1:0] sw;
      sb = {1'b0, ab} + {1'b0, bb};
      sw = aw + bw;
      if (sb >= (BW+1)'(WORD_BITS)) begin
         sb = sb - (BW+1)'(WORD_BITS);
         sw = sw + WW'(1);
      end
      return {sw, sb[BW-1:0]};
   endfunction

   // Bitmap memory.
   logic [WORD_BITS-1:0] mem [MAX_WORDS];
   logic                 mem_we;
   logic [AW-1:0]        mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic [AW-1:0]        mem_rd_addr;
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= mem[mem_rd_addr];
   end

   state_type            state_ff, state_in;
   logic [LIMIT_W-1:0]   rest_ff, rest_in;
   logic [WW-1:0]        words_ff, words_in;
   logic                 tl_ff, tl_in;
   logic [COUNT_W-1:0]   acc_ff, acc_in;
   logic [WW-1:0]        cw_ff, cw_in;
   logic [WW-1:0]        kw_ff, kw_in, pw_ff, pw_in, sw_ff, sw_in, mw_ff, mw_in;
   logic [BW-1:0]        kb_ff, kb_in, pb_ff, pb_in, sb_ff, sb_in, mb_ff, mb_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_tl_ff, rsp_tl_in;

   logic [WW+BW-1:0]     pos_sum;
   logic [BW:0]          pb_step;
   logic [PCW-1:0]       zero_cnt;
   logic [WORD_BITS-1:0] mark_bit;

   // Count of unmarked bits in the word just read.
   always_comb begin
      zero_cnt = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         zero_cnt = zero_cnt + {{(PCW-1){1'b0}}, ~rd_data_ff[i]};
      end
   end

   assign mark_bit = {{(WORD_BITS-1){1'b0}}, 1'b1} << mb_ff;

   always_comb begin
      state_in     = state_ff;
      rest_in      = rest_ff;
      words_in     = words_ff;
      tl_in        = tl_ff;
      acc_in       = acc_ff;
      cw_in        = cw_ff;
      kw_in        = kw_ff;
      kb_in        = kb_ff;
      pw_in        = pw_ff;
      pb_in        = pb_ff;
      sw_in        = sw_ff;
      sb_in        = sb_ff;
      mw_in        = mw_ff;
      mb_in        = mb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      rsp_tl_in    = rsp_tl_ff;
      req_tready   = 1'b0;
      mem_we       = 1'b0;
      mem_wr_addr  = cw_ff[AW-1:0];
      mem_wr_data  = '0;
      mem_rd_addr  = cw_ff[AW-1:0];
      pos_sum      = '0;
      pb_step      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               // A limit of zero gives no words, just like a limit of one.
               rest_in  = (req_tdata[LIMIT_W-1:0] == '0) ? '0
                                                         : req_tdata[LIMIT_W-1:0] - LIMIT_W'(1);
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (rest_ff >= LIMIT_W'(OVER_AT)) begin
               tl_in    = 1'b1;
               acc_in   = '0;
               state_in = ST_DONE;
            end else begin
               tl_in    = 1'b0;
               acc_in   = COUNT_W'(1);
               cw_in    = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            // Each cleared word takes 2*WORD_BITS off n-1; what is cleared is L.
            if (rest_ff >= LIMIT_W'(DIVISOR)) begin
               mem_we      = 1'b1;
               mem_wr_addr = cw_ff[AW-1:0];
               cw_in       = cw_ff + 1'b1;
               rest_in     = rest_ff - LIMIT_W'(DIVISOR);
            end else begin
               words_in = cw_ff;
               // Candidate k = 0 is the odd number 3; its square is bit 3.
               kw_in    = '0;
               kb_in    = '0;
               pw_in    = '0;
               pb_in    = BW'(3);
               sw_in    = '0;
               sb_in    = BW'(3);
               state_in = ST_SIEVE_TOP;
            end
         end
         ST_SIEVE_TOP: begin
            mem_rd_addr = kw_ff[AW-1:0];
            if (sw_ff >= words_ff) begin
               cw_in    = '0;
               state_in = ST_COUNT_RD;
            end else begin
               state_in = ST_SIEVE_CHK;
            end
         end
         ST_SIEVE_CHK: begin
            if (rd_data_ff[kb_ff]) begin
               state_in = ST_ADV1;
            end else begin
               mw_in    = sw_ff;
               mb_in    = sb_ff;
               state_in = ST_MARK_RD;
            end
         end
         ST_MARK_RD: begin
            mem_rd_addr = mw_ff[AW-1:0];
            state_in    = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            mem_we      = 1'b1;
            mem_wr_addr = mw_ff[AW-1:0];
            mem_wr_data = rd_data_ff | mark_bit;
            pos_sum     = pos_add(mw_ff, mb_ff, pw_ff, pb_ff);
            mw_in       = pos_sum[WW+BW-1:BW];
            mb_in       = pos_sum[BW-1:0];
            state_in    = (pos_sum[WW+BW-1:BW] >= words_ff) ? ST_ADV1 : ST_MARK_RD;
         end
         ST_ADV1: begin
            // Square of the next odd number: add the old p now, the new p next.
            pos_sum = pos_add(sw_ff, sb_ff, pw_ff, pb_ff);
            sw_in   = pos_sum[WW+BW-1:BW];
            sb_in   = pos_sum[BW-1:0];
            pb_step = {1'b0, pb_ff} + (BW+1)'(2);
            if (pb_step >= (BW+1)'(WORD_BITS)) begin
               pb_step = pb_step - (BW+1)'(WORD_BITS);
               pw_in   = pw_ff + 1'b1;
            end
            pb_in = pb_step[BW-1:0];
            if (kb_ff == BW'(WORD_BITS - 1)) begin
               kb_in = '0;
               kw_in = kw_ff + 1'b1;
            end else begin
               kb_in = kb_ff + 1'b1;
            end
            state_in = ST_ADV2;
         end
         ST_ADV2: begin
            pos_sum  = pos_add(sw_ff, sb_ff, pw_ff, pb_ff);
            sw_in    = pos_sum[WW+BW-1:BW];
            sb_in    = pos_sum[BW-1:0];
            state_in = ST_SIEVE_TOP;
         end
         ST_COUNT_RD: begin
            mem_rd_addr = cw_ff[AW-1:0];
            state_in    = (cw_ff >= words_ff) ? ST_DONE : ST_COUNT_ADD;
         end
         ST_COUNT_ADD: begin
            acc_in   = acc_ff + COUNT_W'(zero_cnt);
            cw_in    = cw_ff + 1'b1;
            state_in = ST_COUNT_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = acc_ff;
               rsp_tl_in    = tl_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff      <= rest_in;
      words_ff     <= words_in;
      tl_ff        <= tl_in;
      acc_ff       <= acc_in;
      cw_ff        <= cw_in;
      kw_ff        <= kw_in;
      kb_ff        <= kb_in;
      pw_ff        <= pw_in;
      pb_ff        <= pb_in;
      sw_ff        <= sw_in;
      sb_ff        <= sb_in;
      mw_ff        <= mw_in;
      mb_ff        <= mb_in;
      rsp_count_ff <= rsp_count_in;
      rsp_tl_ff    <= rsp_tl_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - COUNT_W - 1){1'b0}}, rsp_tl_ff, rsp_count_ff};

   // A result that reports an oversized limit never carries a count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tl_ff |-> rsp_count_ff == '0)
      else $error("too_large result with nonzero count");

   // Clearing stays inside the memory and marking inside the words of the run.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR && cw_ff < WW'(MAX_WORDS)) ||
                 (state_ff == ST_MARK_WR && mw_ff < words_ff))
      else $error("bitmap write outside the run");

   // A candidate is only checked while its square lies inside the bitmap.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIEVE_TOP && sw_ff < words_ff |-> kw_ff < words_ff)
      else $error("sieve candidate outside the bitmap");

   // An accepted limit always starts the range check.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_RANGE)
      else $error("accepted limit did not start a run");

endmodule
